// ----- src/mbrs_pkg.sv -----
// ---------------------------------------------------------------------------
// Modbus RTU register slave package
// Shared constants, request descriptor type and CRC-16 byte update.
// ---------------------------------------------------------------------------
package mbrs_pkg;

   localparam int REG_COUNT_DEFAULT   = 16;
   localparam int FRAME_BYTES_DEFAULT = 256;

   // frame byte counter holds 0..256
   localparam int CNT_W = 9;
   // response byte index, longest reply is 3 + 32 data + 2 CRC bytes
   localparam int IDX_W = 6;

   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_INPUT = 1'b1;

   localparam logic [7:0] FN_READ_HOLD    = 8'd3;
   localparam logic [7:0] FN_READ_INPUT   = 8'd4;
   localparam logic [7:0] FN_WRITE_SINGLE = 8'd6;
   localparam logic [7:0] FN_WRITE_MULTI  = 8'd16;

   localparam logic [7:0] EXC_ILLEGAL_FUNCTION = 8'd1;
   localparam logic [7:0] EXC_ILLEGAL_ADDRESS  = 8'd2;
   localparam logic [7:0] EXC_FLAG             = 8'h80;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // one queue entry: either a checked frame or an input register update
   typedef struct packed {
      logic             kind;
      logic             bcast;
      logic [5:0][7:0]  hdr;
      logic [CNT_W-1:0] count;
      logic [3:0]       reg_index;
      logic [15:0]      reg_value;
   } desc_type;

   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) c = (c >> 1) ^ CRC_POLY;
         else      c = c >> 1;
      end
      return c;
   endfunction

endpackage

// ----- src/mbrs_ram.sv -----
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module mbrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end

endmodule

// ----- src/mbrs_fifo.sv -----
// ---------------------------------------------------------------------------
// Request queue
// Two-entry FIFO between the front and back parts.
// ---------------------------------------------------------------------------
module mbrs_fifo
   import mbrs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_data,
   input  logic     pop,
   output desc_type head,
   output logic     empty,
   output logic     full
);

   desc_type   entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;

   assign head  = entry_ff[rd_ptr_ff];
   assign empty = (cnt_ff == 2'd0);
   assign full  = (cnt_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

// ----- src/mbrs_front.sv -----
// ---------------------------------------------------------------------------
// Request front end
// Store frame bytes, run the CRC, check the frame at its end, queue work.
// ---------------------------------------------------------------------------
module mbrs_front
   import mbrs_pkg::*;
#(
   parameter int FRAME_BYTES = FRAME_BYTES_DEFAULT,
   localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [31:0]   req_tdata,
   input  logic          req_tlast,
   input  logic          req_tuser,
   input  logic [7:0]    slave_address,
   input  logic          fifo_full,
   input  logic          frame_done,
   output logic          push,
   output desc_type      push_data,
   output logic          ram_we,
   output logic [AW-1:0] ram_waddr,
   output logic [7:0]    ram_wdata
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [5:0][7:0]  hdr_ff, hdr_in;
   logic [15:0]      crc_ff, crcp_ff;
   logic [7:0]       prev_ff;
   logic             busy_ff;
   logic             accept, is_frame, store, frame_ok;
   logic [7:0]       rx_byte;

   assign req_tready = !fifo_full && !busy_ff;
   assign accept     = req_tvalid && req_tready;
   assign is_frame   = (req_tuser == KIND_FRAME);
   assign rx_byte    = req_tdata[7:0];
   assign store      = (count_ff < CNT_W'(FRAME_BYTES));

   assign ram_we    = accept && is_frame && store;
   assign ram_waddr = count_ff[AW-1:0];
   assign ram_wdata = rx_byte;

   always_comb begin
      hdr_in = hdr_ff;
      for (int p = 0; p < 6; p++) begin
         if (store && count_ff == CNT_W'(p)) hdr_in[p] = rx_byte;
      end
      count_in = store ? count_ff + CNT_W'(1) : count_ff;
      ovf_in   = ovf_ff || !store;
      frame_ok = !ovf_in && (count_in >= CNT_W'(4))
                 && (hdr_in[0] == slave_address || hdr_in[0] == 8'h00)
                 && (prev_ff == crcp_ff[7:0]) && (rx_byte == crcp_ff[15:8]);
   end

   always_comb begin
      push_data           = '0;
      push_data.kind      = req_tuser;
      push_data.bcast     = (hdr_in[0] == 8'h00);
      push_data.hdr       = hdr_in;
      push_data.count     = count_in;
      push_data.reg_index = req_tdata[11:8];
      push_data.reg_value = req_tdata[27:12];
      push = accept && (!is_frame || (req_tlast && frame_ok));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         hdr_ff   <= '0;
         crc_ff   <= CRC_INIT;
         crcp_ff  <= CRC_INIT;
         busy_ff  <= 1'b0;
      end else begin
         if (frame_done) busy_ff <= 1'b0;
         if (accept && is_frame) begin
            if (req_tlast) begin
               count_ff <= '0;
               ovf_ff   <= 1'b0;
               hdr_ff   <= '0;
               crc_ff   <= CRC_INIT;
               crcp_ff  <= CRC_INIT;
               if (frame_ok) busy_ff <= 1'b1;
            end else begin
               count_ff <= count_in;
               ovf_ff   <= ovf_in;
               hdr_ff   <= hdr_in;
               crcp_ff  <= crc_ff;
               crc_ff   <= crc_update(crc_ff, rx_byte);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_frame) prev_ff <= rx_byte;
   end

endmodule

// ----- src/mbrs_back.sv -----
// ---------------------------------------------------------------------------
// Request back end
// Execute queued frames and updates, emit the response with its CRC.
// ---------------------------------------------------------------------------
module mbrs_back
   import mbrs_pkg::*;
#(
   parameter int REG_COUNT   = REG_COUNT_DEFAULT,
   parameter int FRAME_BYTES = FRAME_BYTES_DEFAULT,
   localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1,
   localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  desc_type      head,
   input  logic          empty,
   output logic          pop,
   output logic [AW-1:0] ram_raddr,
   input  logic [7:0]    ram_rdata,
   output logic          frame_done,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [7:0]    rsp_tdata,
   output logic          rsp_tlast
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_EXEC, ST_WR_A, ST_WR_B, ST_WR_C, ST_EMIT
   } state_type;

   typedef enum logic [1:0] { MODE_READ, MODE_EXC, MODE_ECHO } mode_type;

   state_type        state_ff;
   mode_type         mode_ff;
   desc_type         desc_ff;
   logic             map_sel_ff;
   logic [7:0]       exc_ff;
   logic [IDX_W-1:0] len_ff, j_ff;
   logic [15:0]      crc_ff;
   logic [4:0]       i_ff;
   logic [7:0]       hi_ff;
   logic [15:0]      holding_ff [REG_COUNT];
   logic [15:0]      input_ff   [REG_COUNT];
   logic             rsp_valid_ff, rsp_last_ff, done_ff;
   logic [7:0]       rsp_data_ff;

   logic [7:0]       fn;
   logic [15:0]      addr, qty;
   logic [16:0]      span;
   logic             range_bad;
   logic [CNT_W-1:0] pos_hi, pos_lo;
   logic             slot_free;
   logic [7:0]       data_byte, out_byte;
   logic [IDX_W-1:0] k;
   logic [RW-1:0]    ridx;
   logic [15:0]      rval;

   assign fn        = desc_ff.hdr[1];
   assign addr      = {desc_ff.hdr[2], desc_ff.hdr[3]};
   assign qty       = {desc_ff.hdr[4], desc_ff.hdr[5]};
   assign span      = {1'b0, addr} + {1'b0, qty};
   assign range_bad = (qty > 16'(REG_COUNT)) || (span > 17'(REG_COUNT));

   assign pos_hi    = CNT_W'(7) + {(CNT_W-1)'(i_ff), 1'b0};
   assign pos_lo    = pos_hi + CNT_W'(1);
   assign ram_raddr = (state_ff == ST_WR_B) ? pos_lo[AW-1:0] : pos_hi[AW-1:0];

   assign pop        = (state_ff == ST_IDLE) && !empty;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign frame_done = done_ff;

   // register data of a read reply
   assign k    = j_ff - IDX_W'(3);
   assign ridx = addr[RW-1:0] + RW'(k[IDX_W-1:1]);
   assign rval = map_sel_ff ? input_ff[ridx] : holding_ff[ridx];

   always_comb begin
      data_byte = 8'h00;
      unique case (mode_ff)
         MODE_READ: begin
            if (j_ff == IDX_W'(0))      data_byte = desc_ff.hdr[0];
            else if (j_ff == IDX_W'(1)) data_byte = fn;
            else if (j_ff == IDX_W'(2)) data_byte = {qty[6:0], 1'b0};
            else                        data_byte = k[0] ? rval[7:0] : rval[15:8];
         end
         MODE_EXC: begin
            if (j_ff == IDX_W'(0))      data_byte = desc_ff.hdr[0];
            else if (j_ff == IDX_W'(1)) data_byte = fn + EXC_FLAG;
            else                        data_byte = exc_ff;
         end
         MODE_ECHO: begin
            data_byte = desc_ff.hdr[j_ff[2:0]];
         end
         default: data_byte = 8'h00;
      endcase
      if (j_ff < len_ff)       out_byte = data_byte;
      else if (j_ff == len_ff) out_byte = crc_ff[7:0];
      else                     out_byte = crc_ff[15:8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
         done_ff      <= 1'b0;
         for (int r = 0; r < REG_COUNT; r++) begin
            holding_ff[r] <= '0;
            input_ff[r]   <= '0;
         end
      end else begin
         done_ff <= 1'b0;
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (!empty) begin
                  desc_ff <= head;
                  if (head.kind == KIND_INPUT) begin
                     if ({1'b0, head.reg_index} < 5'(REG_COUNT))
                        input_ff[head.reg_index[RW-1:0]] <= head.reg_value;
                  end else begin
                     state_ff <= ST_EXEC;
                  end
               end
            end
            ST_EXEC: begin
               j_ff       <= '0;
               crc_ff     <= CRC_INIT;
               i_ff       <= '0;
               map_sel_ff <= (fn == FN_READ_INPUT);
               state_ff   <= desc_ff.bcast ? ST_IDLE : ST_EMIT;
               done_ff    <= desc_ff.bcast;
               priority if (fn == FN_READ_HOLD || fn == FN_READ_INPUT) begin
                  if (range_bad) begin
                     mode_ff <= MODE_EXC;
                     exc_ff  <= EXC_ILLEGAL_ADDRESS;
                     len_ff  <= IDX_W'(3);
                  end else begin
                     mode_ff <= MODE_READ;
                     len_ff  <= IDX_W'(3) + {qty[4:0], 1'b0};
                  end
               end else if (fn == FN_WRITE_SINGLE) begin
                  if (addr >= 16'(REG_COUNT)) begin
                     mode_ff <= MODE_EXC;
                     exc_ff  <= EXC_ILLEGAL_ADDRESS;
                     len_ff  <= IDX_W'(3);
                  end else begin
                     holding_ff[addr[RW-1:0]] <= qty;
                     mode_ff <= MODE_ECHO;
                     len_ff  <= IDX_W'(6);
                  end
               end else if (fn == FN_WRITE_MULTI) begin
                  if (range_bad) begin
                     mode_ff <= MODE_EXC;
                     exc_ff  <= EXC_ILLEGAL_ADDRESS;
                     len_ff  <= IDX_W'(3);
                  end else begin
                     mode_ff <= MODE_ECHO;
                     len_ff  <= IDX_W'(6);
                     if (qty != 16'd0) begin
                        state_ff <= ST_WR_A;
                        done_ff  <= 1'b0;
                     end
                  end
               end else begin
                  mode_ff <= MODE_EXC;
                  exc_ff  <= EXC_ILLEGAL_FUNCTION;
                  len_ff  <= IDX_W'(3);
               end
            end
            ST_WR_A: state_ff <= ST_WR_B;
            ST_WR_B: begin
               hi_ff    <= (pos_hi < desc_ff.count) ? ram_rdata : 8'h00;
               state_ff <= ST_WR_C;
            end
            ST_WR_C: begin
               holding_ff[addr[RW-1:0] + RW'(i_ff)] <=
                  {hi_ff, (pos_lo < desc_ff.count) ? ram_rdata : 8'h00};
               i_ff <= i_ff + 5'd1;
               if (i_ff + 5'd1 == qty[4:0] || qty[4:0] == 5'd0 && i_ff == 5'd15) begin
                  state_ff <= desc_ff.bcast ? ST_IDLE : ST_EMIT;
                  done_ff  <= desc_ff.bcast;
               end else begin
                  state_ff <= ST_WR_A;
               end
            end
            ST_EMIT: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= out_byte;
                  rsp_last_ff  <= (j_ff == len_ff + IDX_W'(1));
                  j_ff         <= j_ff + IDX_W'(1);
                  if (j_ff < len_ff) crc_ff <= crc_update(crc_ff, out_byte);
                  if (j_ff == len_ff + IDX_W'(1)) begin
                     state_ff <= ST_IDLE;
                     done_ff  <= 1'b1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ----- src/modbus_rtu_register_slave_top.sv -----
// ---------------------------------------------------------------------------
// Modbus RTU register slave
// Front end, request queue, frame buffer and back end of the slave.
// ---------------------------------------------------------------------------
// Usage: feed request bytes (tuser 0) one per cycle while the front end takes
// them; the front end stores each byte, runs the CRC-16 on the fly and checks
// unit address, length (4 to FRAME_BYTES) and CRC at the byte marked tlast.
// Bad frames are dropped with no reply. A good frame is queued; the front
// then holds off further request bytes until the back end has executed it and
// sent the whole reply, because the back end still reads the frame buffer.
// Input register updates (tuser 1) pass through the same two-entry queue, so
// they take effect in request order. Once set up, a reply of 5 to 37 bytes
// leaves byte by byte through the output register, which waits for
// rsp_tready; a multiple write first reads each register's bytes through the
// single read port of the frame buffer. Broadcast frames execute but send
// nothing. csr_wdata is the unit address.
// ---------------------------------------------------------------------------
module modbus_rtu_register_slave_top
   import mbrs_pkg::*;
#(
   parameter int REG_COUNT   = REG_COUNT_DEFAULT,
   parameter int FRAME_BYTES = FRAME_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // rx_byte[7:0], reg_index[11:8], reg_value[27:12], zero
   input  logic        req_tlast,  // frame_end
   input  logic        req_tuser,  // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // tx_byte[7:0]
   output logic        rsp_tlast   // tx_last
);

   localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

   logic [7:0]    slave_address_ff;
   logic          fifo_full, fifo_empty, push, pop, frame_done;
   desc_type      push_data, head;
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]    ram_wdata, ram_rdata;

   // unit address register, reset to 1
   always_ff @(posedge clock) begin
      if (reset) slave_address_ff <= 8'd1;
      else if (csr_we) slave_address_ff <= csr_wdata;
   end

   mbrs_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tlast, .req_tuser,
      .slave_address(slave_address_ff), .fifo_full, .frame_done,
      .push, .push_data, .ram_we, .ram_waddr, .ram_wdata
   );

   mbrs_fifo u_fifo (
      .clock, .reset, .push, .push_data, .pop, .head,
      .empty(fifo_empty), .full(fifo_full)
   );

   mbrs_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame_ram (
      .clock, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
      .raddr(ram_raddr), .rdata(ram_rdata)
   );

   mbrs_back #(.REG_COUNT(REG_COUNT), .FRAME_BYTES(FRAME_BYTES)) u_back (
      .clock, .reset, .head, .empty(fifo_empty), .pop, .ram_raddr, .ram_rdata,
      .frame_done, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
   );

endmodule

// ----- tb/modbus_rtu_register_slave_top_tb.sv -----
// ---------------------------------------------------------------------------
// Modbus RTU register slave testbench
// Drives request bytes and input register updates through the request stream,
// predicts every reply byte from its own model of the slave and compares the
// reply stream byte by byte, with random idling on both sides.
// ---------------------------------------------------------------------------
module modbus_rtu_register_slave_top_tb;
   import mbrs_pkg::*;

   localparam int NREG = 16;
   localparam int NBUF = 256;
   localparam int LIMIT = 1500000;

   typedef struct packed {
      logic        kind;
      logic [7:0]  rx_byte;
      logic        frame_end;
      logic [3:0]  reg_index;
      logic [15:0] reg_value;
   } req_item_t;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_last;
   } rsp_item_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [7:0]  csr_wdata = 8'd0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = 32'd0;
   logic        req_tlast = 1'b0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;

   modbus_rtu_register_slave_top u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow state of the slave
   logic [7:0]  unit_addr;
   logic [7:0]  rx_frame[NBUF];
   int          rx_count;
   logic        rx_overflow;
   logic [15:0] hold_regs[NREG];
   logic [15:0] input_regs[NREG];

   req_item_t   pending_reqs[$];
   rsp_item_t   reply_bytes[$];
   int          errors = 0;
   int          cycles = 0;
   bit          no_idle = 1'b0;   // last part of the run: no idling
   int          hold_off = 0;     // long receiver stall, cycles left
   int          send_gap = 0;
   int          recv_gap = 0;
   bit          taken = 1'b0;     // offered request accepted at the last rising edge

   task automatic report(input string what);
      errors++;
      $display("mismatch at cycle %0d: %s", cycles, what);
   endtask

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      return c;
   endfunction

   function automatic logic [7:0] frame_at(input int pos);
      return (pos < rx_count) ? rx_frame[pos] : 8'h00;
   endfunction

   function automatic logic [15:0] crc_of(input logic [7:0] b[$]);
      logic [15:0] c;
      c = 16'hFFFF;
      foreach (b[i]) c = crc16_byte(c, b[i]);
      return c;
   endfunction

   // execute a checked frame, return reply bytes without CRC
   function automatic void run_request(output logic [7:0] rsp[$]);
      logic [7:0] fn;
      int addr, qty;
      fn   = frame_at(1);
      addr = {frame_at(2), frame_at(3)};
      qty  = {frame_at(4), frame_at(5)};
      rsp  = {};
      if (fn == FN_READ_HOLD || fn == FN_READ_INPUT) begin
         if (qty > NREG || addr + qty > NREG) begin
            rsp = {frame_at(0), fn + EXC_FLAG, EXC_ILLEGAL_ADDRESS};
            return;
         end
         rsp = {frame_at(0), fn, 8'((qty * 2) & 8'hFF)};
         for (int i = 0; i < qty; i++) begin
            logic [15:0] v;
            v = (fn == FN_READ_INPUT) ? input_regs[addr + i] : hold_regs[addr + i];
            rsp.push_back(v[15:8]);
            rsp.push_back(v[7:0]);
         end
      end else if (fn == FN_WRITE_SINGLE) begin
         if (addr >= NREG) begin
            rsp = {frame_at(0), fn + EXC_FLAG, EXC_ILLEGAL_ADDRESS};
            return;
         end
         hold_regs[addr] = 16'(qty);
         for (int i = 0; i < 6; i++) rsp.push_back(frame_at(i));
      end else if (fn == FN_WRITE_MULTI) begin
         if (qty > NREG || addr + qty > NREG) begin
            rsp = {frame_at(0), fn + EXC_FLAG, EXC_ILLEGAL_ADDRESS};
            return;
         end
         for (int i = 0; i < qty; i++)
            hold_regs[addr + i] = {frame_at(7 + 2 * i), frame_at(8 + 2 * i)};
         for (int i = 0; i < 6; i++) rsp.push_back(frame_at(i));
      end else begin
         rsp = {frame_at(0), fn + EXC_FLAG, EXC_ILLEGAL_FUNCTION};
      end
   endfunction

   // advance the shadow state by one accepted request, queue its reply
   function automatic void predict_request(input req_item_t it);
      logic [7:0] rsp[$];
      logic [7:0] body[$];
      logic [15:0] c;
      if (it.kind == KIND_INPUT) begin
         input_regs[it.reg_index] = it.reg_value;
         return;
      end
      if (rx_count < NBUF) rx_frame[rx_count++] = it.rx_byte;
      else rx_overflow = 1'b1;
      if (!it.frame_end) return;
      if (!rx_overflow && rx_count >= 4 &&
          (rx_frame[0] == unit_addr || rx_frame[0] == 8'h00)) begin
         body = {};
         for (int i = 0; i + 2 < rx_count; i++) body.push_back(rx_frame[i]);
         c = crc_of(body);
         if (rx_frame[rx_count-2] == c[7:0] && rx_frame[rx_count-1] == c[15:8]) begin
            run_request(rsp);
            if (rx_frame[0] != 8'h00) begin
               c = crc_of(rsp);
               rsp.push_back(c[7:0]);
               rsp.push_back(c[15:8]);
               foreach (rsp[i]) reply_bytes.push_back({rsp[i], 1'(i == rsp.size() - 1)});
            end
         end
      end
      rx_count = 0;
      rx_overflow = 1'b0;
   endfunction

   // queue helpers
   function automatic void push_byte(input logic [7:0] b, input logic last);
      pending_reqs.push_back('{KIND_FRAME, b, last, 4'($urandom), 16'($urandom)});
   endfunction

   function automatic void push_frame(input logic [7:0] body[$], input int crc_mode);
      logic [15:0] c;
      c = crc_of(body);
      if (crc_mode == 1) c ^= 16'(1 << $urandom_range(15, 0));
      foreach (body[i]) push_byte(body[i], 1'b0);
      push_byte(c[7:0], 1'b0);
      push_byte(c[15:8], 1'b1);
   endfunction

   function automatic void push_update(input logic [3:0] idx, input logic [15:0] v);
      pending_reqs.push_back('{KIND_INPUT, 8'($urandom), 1'($urandom), idx, v});
   endfunction

   // random request with random content, at times short or with a bad CRC
   function automatic void push_random_frame(input logic [7:0] unit);
      logic [7:0] body[$];
      logic [7:0] fn;
      int addr, qty, sel;
      sel = $urandom_range(9, 0);
      case (sel)
         0, 1: fn = FN_READ_HOLD;
         2, 3: fn = FN_READ_INPUT;
         4, 5: fn = FN_WRITE_SINGLE;
         6, 7: fn = FN_WRITE_MULTI;
         default: fn = 8'($urandom);
      endcase
      qty  = ($urandom_range(7, 0) == 0) ? $urandom_range(65535, 0) : $urandom_range(NREG, 0);
      addr = ($urandom_range(7, 0) == 0) ? $urandom_range(65535, 0)
                                        : $urandom_range(NREG - 1, 0);
      if (fn == FN_READ_HOLD || fn == FN_READ_INPUT || fn == FN_WRITE_MULTI)
         if ($urandom_range(4, 0) != 0 && addr + qty > NREG) qty = NREG - addr;
      if (fn == FN_WRITE_SINGLE) qty = $urandom_range(65535, 0);
      body = {unit, fn, 8'(addr >> 8), 8'(addr), 8'(qty >> 8), 8'(qty)};
      if (fn == FN_WRITE_MULTI) begin
         body.push_back(8'(qty * 2));
         for (int i = 0; i < 2 * (qty % 32); i++) body.push_back(8'($urandom));
      end
      if ($urandom_range(5, 0) == 0)
         while (body.size() > 2) void'(body.pop_back());   // short request
      push_frame(body, ($urandom_range(9, 0) == 0) ? 1 : 0);
   endfunction

   // accept at the rising edge; predict, drop the request from the queue, check
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_request({req_tuser, req_tdata[7:0], req_tlast, req_tdata[11:8],
                             req_tdata[27:12]});
            void'(pending_reqs.pop_front());
            taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (reply_bytes.size() == 0)
               report($sformatf("unexpected reply byte %02h", rsp_tdata));
            else begin
               rsp_item_t e;
               e = reply_bytes.pop_front();
               if (rsp_tdata !== e.tx_byte)
                  report($sformatf("tx_byte %02h, want %02h", rsp_tdata, e.tx_byte));
               if (rsp_tlast !== e.tx_last)
                  report($sformatf("tx_last %0b, want %0b", rsp_tlast, e.tx_last));
            end
         end
      end
   end

   // long receiver stall, counted down once per cycle
   always @(posedge clock) begin
      if (hold_off > 0) hold_off--;
   end

   // present the next request and the receiver ready; run idle bursts
   bit send_pause = 1'b0;
   always @(negedge clock) begin
      req_item_t nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         // sender: hold valid once raised until accepted
         if (!(req_tvalid && !taken)) begin
            if (send_gap > 0) send_gap--;
            else if (!no_idle && $urandom_range(5, 0) == 0) send_gap = $urandom_range(4, 1);
         end
         if (req_tvalid && !taken) begin
            // stay on the offered request
         end else if (pending_reqs.size() > 0 && send_gap == 0 && !send_pause) begin
            nxt = pending_reqs[0];
            req_tvalid <= 1'b1;
            req_tdata  <= {4'd0, nxt.reg_value, nxt.reg_index, nxt.rx_byte};
            req_tlast  <= nxt.frame_end;
            req_tuser  <= nxt.kind;
         end else
            req_tvalid <= 1'b0;
         taken = 1'b0;
         // receiver
         if (hold_off > 0) begin
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else if (!no_idle && $urandom_range(5, 0) == 0) begin
            recv_gap = $urandom_range(3, 0);
            rsp_tready <= 1'b0;
         end else
            rsp_tready <= 1'b1;
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || reply_bytes.size() != 0 || req_tvalid)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic set_unit(input logic [7:0] a);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= a;
      @(negedge clock);
      csr_we    <= 1'b0;
      unit_addr = a;
   endtask

   initial begin
      logic [7:0] addrs[4];
      unit_addr   = 8'd1;
      rx_count    = 0;
      rx_overflow = 1'b0;
      for (int i = 0; i < NREG; i++) begin
         hold_regs[i]  = 16'h0;
         input_regs[i] = 16'h0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: every function, exceptions, broadcast, bad frames
      push_update(4'd0, 16'hFFFF);
      push_update(4'd15, 16'h0000);
      push_update(4'd7, 16'hA55A);
      push_frame('{8'd1, FN_READ_INPUT, 8'd0, 8'd0, 8'd0, 8'd16}, 0);
      push_frame('{8'd1, FN_WRITE_SINGLE, 8'd0, 8'd15, 8'hFF, 8'hFF}, 0);
      push_frame('{8'd1, FN_READ_HOLD, 8'd0, 8'd15, 8'd0, 8'd1}, 0);
      push_frame('{8'd1, FN_READ_HOLD, 8'd0, 8'd0, 8'd0, 8'd0}, 0);
      push_frame('{8'd1, FN_READ_HOLD, 8'd0, 8'd8, 8'd0, 8'd9}, 0);
      push_frame('{8'd1, FN_READ_INPUT, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 0);
      push_frame('{8'd1, FN_WRITE_SINGLE, 8'd0, 8'd16, 8'd1, 8'd2}, 0);
      push_frame('{8'd1, FN_WRITE_MULTI, 8'd0, 8'd14, 8'd0, 8'd2, 8'd4,
                   8'h12, 8'h34, 8'hAB, 8'hCD}, 0);
      push_frame('{8'd1, FN_WRITE_MULTI, 8'd0, 8'd3, 8'd0, 8'd0, 8'd0}, 0);
      push_frame('{8'd1, FN_WRITE_MULTI, 8'd0, 8'd10, 8'd0, 8'd7, 8'd14}, 0);
      push_frame('{8'd1, 8'hFF}, 0);                      // exception code wraps
      push_frame('{8'd1, 8'd0, 8'd0}, 0);                 // short request
      push_frame('{8'd0, FN_WRITE_SINGLE, 8'd0, 8'd1, 8'hBE, 8'hEF}, 0); // broadcast
      push_frame('{8'd1, FN_READ_HOLD, 8'd0, 8'd0, 8'd0, 8'd2}, 1);     // bad CRC
      push_frame('{8'd9, FN_READ_HOLD, 8'd0, 8'd0, 8'd0, 8'd2}, 0);     // other unit
      push_byte(8'd1, 1'b0); push_byte(8'd3, 1'b0); push_byte(8'd0, 1'b1); // too short
      push_byte(8'd1, 1'b1);
      push_frame('{8'd1, FN_READ_HOLD, 8'd0, 8'd0, 8'd0, 8'd16}, 0);
      // long receiver stall while requests keep coming
      hold_off = 300;
      for (int i = 0; i < 4; i++)
         push_frame('{8'd1, FN_READ_INPUT, 8'd0, 8'd0, 8'd0, 8'd16}, 0);
      wait_drained();

      // random phases over several unit addresses, extremes included
      addrs = '{8'd247, 8'd1, 8'($urandom_range(246, 2)), 8'd128};
      for (int ph = 0; ph < 4; ph++) begin
         set_unit(addrs[ph]);
         for (int n = 0; n < 2; n++) begin
            case ($urandom_range(9, 0))
               0:    push_update(4'($urandom), 16'($urandom));
               1:    push_random_frame(8'($urandom));
               2:    push_byte(8'($urandom), 1'($urandom));
               3:    push_random_frame(8'd0);
               default: push_random_frame(addrs[ph]);
            endcase
         end
         if (ph == 3) no_idle = 1'b1;
         // pause the sender until all replies are back
         if (ph == 1) begin
            while (pending_reqs.size() != 0) @(posedge clock);
            send_pause = 1'b1;
            while (reply_bytes.size() != 0) @(posedge clock);
            send_pause = 1'b0;
            for (int n = 0; n < 2; n++) push_random_frame(addrs[ph]);
         end
         wait_drained();
      end

      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (cycles >= LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule

// ----- files.f -----
src/mbrs_pkg.sv
src/mbrs_ram.sv
src/mbrs_fifo.sv
src/mbrs_front.sv
src/mbrs_back.sv
src/modbus_rtu_register_slave_top.sv
tb/modbus_rtu_register_slave_top_tb.sv
